@@ design/tevd_pkg.sv @@
package tevd_pkg;

  localparam int NUM_SLOTS_DEF = 10;
  localparam int SLOT_LIMIT    = 16;
  localparam int SIZE_W        = 17;
  localparam int COORD_W       = 16;
  localparam int MASK_W        = 10;
  localparam int CFG_IDX_W     = 2;

  localparam logic [16:0] SIZE_X_RST = 17'd14400;
  localparam logic [16:0] SIZE_Y_RST = 17'd32000;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_COORD = 2'd2;

  // Event codes in byte 0
  localparam logic [7:0] EVT_NONE   = 8'h00;
  localparam logic [7:0] EVT_READY  = 8'h03;
  localparam logic [7:0] EVT_ENTER  = 8'h13;
  localparam logic [7:0] EVT_MOTION = 8'h23;
  localparam logic [7:0] EVT_LEAVE  = 8'h33;

  localparam logic MODE_DECODE  = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_CONTACT = 3'd1,
    ACT_LIFT    = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_RESTART = 3'd4
  } action_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] event_id;
    logic [7:0] slot_byte;
    logic [7:0] x_low;
    logic [7:0] xy_mix;
    logic [7:0] y_byte;
    logic [7:0] angle_or_yhigh;
    logic [7:0] area_byte;
    logic [7:0] extra_byte;
    logic       first_in_batch;
    logic       last_in_batch;
  } evt_t;

  typedef struct packed {
    action_t                action;
    logic [3:0]             slot;
    logic [COORD_W-1:0]     pos_x;
    logic [COORD_W-1:0]     pos_y;
    logic [9:0]             touch_major;
    logic [9:0]             touch_minor;
    logic signed [7:0]      orientation;
    logic                   touching;
    logic [MASK_W-1:0]      active_mask;
    logic                   frame_end;
  } res_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic              wide_coord;
  } cfg_t;

  // Clamp a coordinate to size - 1; a size of zero clamps to zero
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v,
                                                     input logic [SIZE_W-1:0]  size);
    logic [SIZE_W-1:0] lim;
    lim = (size == '0) ? '0 : size - 1'b1;
    if ({1'b0, v} > lim) begin
      return lim[COORD_W-1:0];
    end
    return v;
  endfunction

endpackage

@@ design/touch_event_decoder.sv @@
// Channel   Direction  Handshake            Payload
// evt       in         evt_valid/evt_stall  tevd_pkg::evt_t, one FIFO event or release-all
// res       out        res_valid/res_stall  tevd_pkg::res_t, one result per event
// cfg       in         cfg_we               cfg_index selects size_x, size_y, wide_coord
//
// One request per cycle sustained while res_stall is low; a request accepted into the input
// register is decoded combinationally and loaded into the result register when it advances.
// Slot mask, touching flag and batch skip state advance when a request enters the result
// register, so results leave in request order.
// Reset (rst, synchronous) empties both registers, clears all state and restores the sizes.
// A stall on the result side holds the result; the input register takes one more request,
// then evt_stall stays high while it is full and the result is held.
module touch_event_decoder #(
  parameter int NUM_SLOTS = tevd_pkg::NUM_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               evt_valid,
  output logic                               evt_stall,
  input  tevd_pkg::evt_t                     evt,
  output logic                               res_valid,
  input  logic                               res_stall,
  output tevd_pkg::res_t                     res,
  input  logic                               cfg_we,
  input  logic [tevd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tevd_pkg::SIZE_W-1:0]        cfg_data
);
  import tevd_pkg::*;

  // Configuration registers
  cfg_t cfg;

  // Input register
  logic evt_full;
  evt_t evt_hold;

  // Decoder state
  logic [NUM_SLOTS-1:0] active;
  logic                 touch;
  logic                 skip;

  logic [NUM_SLOTS-1:0] active_next;
  logic                 touch_next;
  logic                 skip_next;
  res_t                 res_next;

  logic advance;

  // Move the held request forward when the result register is empty or being drained
  assign advance   = evt_full && (!res_valid || !res_stall);
  assign evt_stall = evt_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x     <= SIZE_X_RST;
      cfg.size_y     <= SIZE_Y_RST;
      cfg.wide_coord <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X:     cfg.size_x     <= cfg_data;
        REG_SIZE_Y:     cfg.size_y     <= cfg_data;
        REG_WIDE_COORD: cfg.wide_coord <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // Capture a request whenever the input register is free or emptying
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_full <= 1'b0;
    end else if (evt_valid && !evt_stall) begin
      evt_full <= 1'b1;
    end else if (advance) begin
      evt_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && !evt_stall) begin
      evt_hold <= evt;
    end
  end

  tevd_decode #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_decode (
    .evt         (evt_hold),
    .cfg         (cfg),
    .active      (active),
    .touch       (touch),
    .skip        (skip),
    .res         (res_next),
    .active_next (active_next),
    .touch_next  (touch_next),
    .skip_next   (skip_next)
  );

  // State advances together with the result register load
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      touch  <= 1'b0;
      skip   <= 1'b0;
    end else if (advance) begin
      active <= active_next;
      touch  <= touch_next;
      skip   <= skip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

@@ design/tevd_decode.sv @@
module tevd_decode #(
  parameter int NUM_SLOTS = tevd_pkg::NUM_SLOTS_DEF
) (
  input  tevd_pkg::evt_t        evt,
  input  tevd_pkg::cfg_t        cfg,
  input  logic [NUM_SLOTS-1:0]  active,
  input  logic                  touch,
  input  logic                  skip,
  output tevd_pkg::res_t        res,
  output logic [NUM_SLOTS-1:0]  active_next,
  output logic                  touch_next,
  output logic                  skip_next
);
  import tevd_pkg::*;

  localparam logic [4:0] SLOT_CNT = 5'(NUM_SLOTS);

  logic [3:0]           slot;
  logic                 slot_ok;
  logic [NUM_SLOTS-1:0] slot_hot;
  logic [COORD_W-1:0]   x;
  logic [COORD_W-1:0]   y;
  logic [5:0]           major;
  logic [5:0]           minor;
  logic [SLOT_LIMIT-1:0] mask_wide;
  logic                 skipping;

  assign slot     = evt.slot_byte[7:4];
  assign slot_ok  = {1'b0, slot} < SLOT_CNT;
  assign slot_hot = {{(NUM_SLOTS-1){1'b0}}, 1'b1} << slot;
  assign major    = {evt.event_id[3:2], evt.area_byte[7:4]};
  assign minor    = {evt.extra_byte[7:6], evt.area_byte[3:0]};

  always_comb begin
    if (cfg.wide_coord) begin
      x = {evt.xy_mix, evt.x_low};
      y = {evt.angle_or_yhigh, evt.y_byte};
    end else begin
      x = {4'd0, evt.xy_mix[3:0], evt.x_low};
      y = {4'd0, evt.y_byte, evt.xy_mix[7:4]};
    end
  end

  always_comb begin
    res         = '0;
    res.action  = ACT_NONE;
    active_next = active;
    touch_next  = touch;
    skip_next   = skip;
    skipping    = 1'b0;
    if (evt.mode == MODE_RELEASE) begin
      res.action  = ACT_RELEASE;
      active_next = '0;
      touch_next  = 1'b0;
      res.frame_end = 1'b1;
    end else begin
      skipping      = skip && !evt.first_in_batch;
      res.frame_end = evt.last_in_batch;
      if (!skipping) begin
        case (evt.event_id)
          EVT_NONE: begin
            skipping = 1'b1;
          end
          EVT_ENTER, EVT_MOTION: begin
            if (slot_ok) begin
              res.action      = ACT_CONTACT;
              res.slot        = slot;
              res.pos_x       = clamp_coord(x, cfg.size_x);
              res.pos_y       = clamp_coord(y, cfg.size_y);
              res.touch_major = {major, 4'd0};
              res.touch_minor = {minor, 4'd0};
              res.orientation = cfg.wide_coord ? 8'sd0 : $signed(evt.angle_or_yhigh);
              active_next     = active | slot_hot;
              touch_next      = 1'b1;
            end
          end
          EVT_LEAVE: begin
            if (slot_ok) begin
              res.action  = ACT_LIFT;
              res.slot    = slot;
              active_next = active & ~slot_hot;
              if ((active & ~slot_hot) == '0) begin
                touch_next = 1'b0;
              end
            end
          end
          EVT_READY: begin
            res.action = ACT_RESTART;
          end
          default: begin
            res.action = ACT_NONE;
          end
        endcase
      end
      skip_next = skipping && !evt.last_in_batch;
    end
    res.touching    = touch_next;
    mask_wide       = SLOT_LIMIT'(active_next);
    res.active_mask = mask_wide[MASK_W-1:0];
  end

endmodule

@@ design/tevd_checker.sv @@
module tevd_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_stall,
  input tevd_pkg::res_t res
);
  import tevd_pkg::*;

  // Hold a stalled result unchanged
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_release: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.action == ACT_RELEASE |->
      res.active_mask == '0 && !res.touching && res.frame_end)
    else $error("release did not clear state");

  a_contact_touch: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.action == ACT_CONTACT |-> res.touching)
    else $error("contact without touching");

  a_idle_mask: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.touching |-> res.active_mask == '0)
    else $error("slots active while not touching");

endmodule

bind touch_event_decoder tevd_checker u_tevd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
